// File: src/llrp_pkg.sv
// Package for the least-loaded row packer: shared widths, default
// parameter values, register indices and the record types of the cell chain.
// No dependencies.
package llrp_pkg;

    localparam int MAX_ROWS_DEF   = 16;
    localparam int MAX_GLYPHS_DEF = 256;
    localparam int WIDTH_BITS_DEF = 12;

    localparam int GW_W    = 12;   // glyph_width field
    localparam int ROW_W   = 4;    // chosen_row field
    localparam int NUM_W   = 8;    // glyph_number field
    localparam int SUM_W   = 21;   // row sums, x_offset, widest_row
    localparam int CNT_W   = 5;    // row_count register
    localparam int PAD_W   = 8;    // pad_amount register
    localparam int IDX_W   = 6;    // row index inside the chain (up to 64 rows)
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD       = 1'b1;

    // running result carried along the chain
    typedef struct packed {
        logic [SUM_W-1:0] best_val;
        logic [IDX_W-1:0] best_idx;
        logic [SUM_W-1:0] max_val;
    } rec_t;

    // row update broadcast to every cell
    typedef struct packed {
        logic             clear;
        logic             write;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] value;
    } upd_t;

endpackage

// File: src/llrp_if.sv
// Valid/ready channel interfaces of the least-loaded row packer.
// Depends on llrp_pkg for field widths.
interface llrp_in_if;
    logic                       valid;
    logic                       ready;
    logic [llrp_pkg::GW_W-1:0]  glyph_width;
    logic                       final_glyph;

    modport source (output valid, output glyph_width, output final_glyph, input ready);
    modport sink   (input valid, input glyph_width, input final_glyph, output ready);
endinterface

interface llrp_out_if;
    logic                       valid;
    logic                       ready;
    logic [llrp_pkg::ROW_W-1:0] chosen_row;
    logic [llrp_pkg::NUM_W-1:0] glyph_number;
    logic [llrp_pkg::SUM_W-1:0] x_offset;
    logic [llrp_pkg::SUM_W-1:0] widest_row;
    logic                       run_done;

    modport source (output valid, output chosen_row, output glyph_number, output x_offset,
                    output widest_row, output run_done, input ready);
    modport sink   (input valid, input chosen_row, input glyph_number, input x_offset,
                    input widest_row, input run_done, output ready);
endinterface

// File: src/least_loaded_row_packer.sv
// Least-loaded row packer top level: chain of row cells plus controller.
// Depends on llrp_pkg, llrp_in_if / llrp_out_if and llrp_cell.
//
// Use: glyph widths arrive on glyph_in (valid/ready); one result per glyph
// leaves on result_out (valid/ready). Each glyph goes to the narrowest of the
// first row_count rows (lowest index on a tie); x_offset is that row's width
// with leading padding before placement. On a glyph with final_glyph set the
// result also carries widest_row and run_done, and all rows clear.
// Configuration: cfg_we / cfg_index / cfg_data, index 0 row_count, 1 pad_amount;
// write only while no glyph is in flight.
// Timing: the transfer edge loads the first cell, the search record then walks
// the remaining MAX_ROWS - 1 cells at one cell per cycle, goes into the hold
// register, and then updates the row and loads the output register; a new glyph
// is taken the cycle after that, so only one glyph is in the chain at a time.
// If the receiver stalls, the finished record waits in the controller and
// glyph_in stays not ready until the output register frees.
// Reset clears all rows, the glyph counter and the output valid, and sets
// row_count to 1 and pad_amount to 0.
module least_loaded_row_packer #(
    parameter int MAX_ROWS   = llrp_pkg::MAX_ROWS_DEF,
    parameter int MAX_GLYPHS = llrp_pkg::MAX_GLYPHS_DEF,
    parameter int WIDTH_BITS = llrp_pkg::WIDTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [llrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [llrp_pkg::CFG_DATA_W-1:0]  cfg_data,
    llrp_in_if.sink                          glyph_in,
    llrp_out_if.source                       result_out
);

    localparam int USE_BITS = (WIDTH_BITS < llrp_pkg::GW_W) ? WIDTH_BITS : llrp_pkg::GW_W;
    localparam int GC_W     = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int SW       = llrp_pkg::SUM_W;

    // configuration
    logic [llrp_pkg::CNT_W-1:0] row_count_reg;
    logic [llrp_pkg::PAD_W-1:0] pad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= llrp_pkg::CNT_W'(1);
            pad_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                llrp_pkg::REG_ROW_COUNT: row_count_reg <= llrp_pkg::CNT_W'(cfg_data);
                llrp_pkg::REG_PAD:       pad_reg       <= llrp_pkg::PAD_W'(cfg_data);
                default:                 ;
            endcase
        end
    end

    // control
    logic                 busy_reg;
    logic                 pend_reg;
    llrp_pkg::rec_t       pend_rec_reg;
    logic [USE_BITS-1:0]  width_reg;
    logic                 final_reg;
    logic [GC_W-1:0]      gc_reg;
    logic [GC_W-1:0]      gc_next;
    logic                 out_valid_reg;
    logic                 in_xfer;
    logic                 finish;

    // chain
    logic [MAX_ROWS:0]    chain_valid;
    llrp_pkg::rec_t       chain_rec [MAX_ROWS+1];
    llrp_pkg::upd_t       upd;

    assign in_xfer        = glyph_in.valid && glyph_in.ready;
    assign glyph_in.ready = !busy_reg;
    assign finish         = pend_reg && (!out_valid_reg || result_out.ready);

    assign chain_valid[0]        = in_xfer;
    assign chain_rec[0].best_val = llrp_pkg::SUM_MAX;
    assign chain_rec[0].best_idx = '0;
    assign chain_rec[0].max_val  = '0;

    for (genvar g = 0; g < MAX_ROWS; g++)
    begin : g_cell
        llrp_cell #(.IDX(g)) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .row_count     (row_count_reg),
            .rec_in_valid  (chain_valid[g]),
            .rec_in        (chain_rec[g]),
            .rec_out_valid (chain_valid[g+1]),
            .rec_out       (chain_rec[g+1]),
            .upd           (upd)
        );
    end

    // placement arithmetic
    logic [SW-1:0] inc;
    logic [SW:0]   new_raw;
    logic [SW-1:0] new_sum;
    logic [SW:0]   off_raw;
    logic [SW-1:0] offset;
    logic [SW-1:0] mx;
    logic [SW:0]   wide_raw;
    logic [SW-1:0] widest;

    always_comb
    begin
        inc      = SW'(width_reg) + SW'(pad_reg);
        new_raw  = {1'b0, pend_rec_reg.best_val} + {1'b0, inc};
        new_sum  = new_raw[SW] ? llrp_pkg::SUM_MAX : new_raw[SW-1:0];
        off_raw  = {1'b0, pend_rec_reg.best_val} + (SW+1)'(pad_reg);
        offset   = off_raw[SW] ? llrp_pkg::SUM_MAX : off_raw[SW-1:0];
        mx       = (new_sum > pend_rec_reg.max_val) ? new_sum : pend_rec_reg.max_val;
        wide_raw = {1'b0, mx} + (SW+1)'(pad_reg);
        widest   = wide_raw[SW] ? llrp_pkg::SUM_MAX : wide_raw[SW-1:0];

        upd.clear = finish && final_reg;
        upd.write = finish && !final_reg;
        upd.idx   = pend_rec_reg.best_idx;
        upd.value = new_sum;

        if (final_reg || (gc_reg == GC_W'(MAX_GLYPHS - 1)))
        begin
            gc_next = '0;
        end
        else
        begin
            gc_next = gc_reg + GC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            gc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (chain_valid[MAX_ROWS])
            begin
                pend_reg <= 1'b1;
            end
            else if (finish)
            begin
                pend_reg <= 1'b0;
            end

            if (finish)
            begin
                gc_reg        <= gc_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    logic [llrp_pkg::ROW_W-1:0] row_reg;
    logic [llrp_pkg::NUM_W-1:0] num_reg;
    logic [SW-1:0]              off_reg;
    logic [SW-1:0]              wide_reg;
    logic                       done_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            width_reg <= glyph_in.glyph_width[USE_BITS-1:0];
            final_reg <= glyph_in.final_glyph;
        end
        if (chain_valid[MAX_ROWS])
        begin
            pend_rec_reg <= chain_rec[MAX_ROWS];
        end
        if (finish)
        begin
            row_reg  <= llrp_pkg::ROW_W'(pend_rec_reg.best_idx);
            num_reg  <= llrp_pkg::NUM_W'(gc_reg);
            off_reg  <= offset;
            wide_reg <= final_reg ? widest : '0;
            done_reg <= final_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.chosen_row   = row_reg;
    assign result_out.glyph_number = num_reg;
    assign result_out.x_offset     = off_reg;
    assign result_out.widest_row   = wide_reg;
    assign result_out.run_done     = done_reg;

    // checks
    a_one_search: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one search record in the chain");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !glyph_in.ready)
        else $error("glyph accepted while a search is in flight");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg)
        else $error("pending record without a glyph in flight");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && final_reg) |=> (gc_reg == '0))
        else $error("glyph counter not cleared at run end");

    a_tail_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[MAX_ROWS] |-> !pend_reg)
        else $error("search record overwrote a pending record");

endmodule

// File: src/llrp_cell.sv
// One row cell: holds a row sum, folds it into the passing min/max record
// and registers the record for its neighbour. Depends on llrp_pkg.
module llrp_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [llrp_pkg::CNT_W-1:0]    row_count,
    input  logic                          rec_in_valid,
    input  llrp_pkg::rec_t                rec_in,
    output logic                          rec_out_valid,
    output llrp_pkg::rec_t                rec_out,
    input  llrp_pkg::upd_t                upd
);

    logic [llrp_pkg::SUM_W-1:0] sum_reg;
    logic                       rec_valid_reg;
    llrp_pkg::rec_t             rec_reg;
    llrp_pkg::rec_t             rec_next;
    logic                       active;

    assign active = (IDX == 0) || (IDX < int'(row_count));

    always_comb
    begin
        rec_next = rec_in;
        if (active && (sum_reg < rec_in.best_val))
        begin
            rec_next.best_val = sum_reg;
            rec_next.best_idx = llrp_pkg::IDX_W'(IDX);
        end
        if (active && (sum_reg > rec_in.max_val))
        begin
            rec_next.max_val = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_in_valid;
            if (upd.clear)
            begin
                sum_reg <= '0;
            end
            else if (upd.write && (upd.idx == llrp_pkg::IDX_W'(IDX)))
            begin
                sum_reg <= upd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_in_valid)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out_valid = rec_valid_reg;
    assign rec_out       = rec_reg;

endmodule
